/* src/gld_pkg.sv */
package gld_pkg;

  localparam int PIN_W        = 5;
  localparam int TIME_W       = 64;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_PINS_DEF = 32;

  // usable pins minus the flash interface pins
  localparam logic [CFG_W-1:0] VALID_BASE  = 32'h03FF6FFF;
  localparam logic [CFG_W-1:0] FLASH_PINS  = 32'h00FA0000;
  localparam logic [CFG_W-1:0] VALID_RESET = VALID_BASE & ~FLASH_PINS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALID_PINS = 2'd0,
    CFG_REQ_IN     = 2'd1,
    CFG_REQ_OUT    = 2'd2,
    CFG_DEBOUNCE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } gld_state_t;

endpackage

/* src/gld_times.sv */
module gld_times #(
  parameter int NUM_PINS = 32,
  parameter int IDX_W    = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [gld_pkg::TIME_W-1:0] wr_data,
  input  logic [IDX_W-1:0]          rd_idx,
  output logic [gld_pkg::TIME_W-1:0] rd_time
);
  import gld_pkg::*;

  logic [TIME_W-1:0] mem [NUM_PINS];
  logic [NUM_PINS-1:0] tv_r;
  logic [TIME_W-1:0] rd_time_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_time_r <= mem[rd_idx];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        tv_r[wr_idx] <= 1'b1;
      end
      rd_vld_r <= tv_r[rd_idx];
    end
  end

  assign rd_time = rd_vld_r ? rd_time_r : '0;

endmodule

/* src/gpio_lockout_debouncer.sv */
// Walk: an item walks the pins one per cycle, then enters a flush state when it
// yields at least one event; a stalled result channel extends the walk.
// A new item is accepted only after the walk and any flush are done; the walk is
// paced by the single timestamp memory read and one 64-bit lockout compare per pin.
// Reset (synchronous, rst_n low): registers take their reset values, accepted
// levels clear and all pin change times read as zero until written.
module gpio_lockout_debouncer #(
  parameter int NUM_PINS = gld_pkg::NUM_PINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_pin_levels,
  input  logic [gld_pkg::TIME_W-1:0]    in_now_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gld_pkg::PIN_W-1:0]     out_pin_index,
  output logic                          out_pressed,
  output logic                          out_last_event,
  input  logic                          cfg_we,
  input  logic [gld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gld_pkg::CFG_W-1:0]     cfg_wdata
);
  import gld_pkg::*;

  localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [IDX_W-1:0] LAST_PIN = IDX_W'(NUM_PINS - 1);

  // configuration
  logic [CFG_W-1:0] valid_r, req_in_r, req_out_r, deb_r;

  gld_state_t st_r, st_nxt;
  logic [IDX_W-1:0]    cur_r;
  logic [NUM_PINS-1:0] lvl_r, chg_r, sample_r;
  logic [TIME_W-1:0]   now_r;
  logic                pend_vld_r;
  logic [IDX_W-1:0]    pend_idx_r;
  logic                pend_prs_r;
  logic                out_valid_r;
  logic [PIN_W-1:0]    out_idx_r;
  logic                out_prs_r;
  logic                out_last_r;

  logic [CFG_W-1:0]    eff_mask;
  logic [NUM_PINS-1:0] sample_in;
  logic                in_acc, out_free, acc, adv, last_pin, emit_mid, emit_last;
  logic [TIME_W:0]     diff;
  logic [TIME_W-1:0]   last_time;
  logic [IDX_W-1:0]    rd_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= VALID_RESET;
      req_in_r  <= '0;
      req_out_r <= '0;
      deb_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VALID_PINS: valid_r   <= cfg_wdata;
        CFG_REQ_IN:     req_in_r  <= cfg_wdata;
        CFG_REQ_OUT:    req_out_r <= cfg_wdata;
        CFG_DEBOUNCE:   deb_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_mask  = valid_r & ~((req_out_r & ~req_in_r) & valid_r);
  assign sample_in = in_pin_levels[NUM_PINS-1:0] & eff_mask[NUM_PINS-1:0];

  gld_times #(
    .NUM_PINS (NUM_PINS),
    .IDX_W    (IDX_W)
  ) u_times (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (adv && acc),
    .wr_idx  (cur_r),
    .wr_data (now_r),
    .rd_idx  (rd_idx),
    .rd_time (last_time)
  );

  // lockout over when last <= now and now - last >= debounce
  assign diff = {1'b0, now_r} - {1'b0, last_time};

  always_comb begin
    in_acc    = in_valid && (st_r == ST_IDLE);
    out_free  = !out_valid_r || !out_stall;
    last_pin  = (cur_r == LAST_PIN);
    acc       = (st_r == ST_WALK) && chg_r[cur_r] && !diff[TIME_W] &&
                (diff[TIME_W-1:0] >= {{(TIME_W-CFG_W){1'b0}}, deb_r});
    // a new event pushes the pending one out, so it needs a free output slot
    adv       = (st_r == ST_WALK) && (!acc || !pend_vld_r || out_free);
    emit_mid  = adv && acc && pend_vld_r;
    emit_last = (st_r == ST_FLUSH) && out_free;
    if (st_r == ST_WALK) begin
      rd_idx = (adv && !last_pin) ? cur_r + 1'b1 : cur_r;
    end else begin
      rd_idx = '0;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) st_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (adv && last_pin) st_nxt = (pend_vld_r || acc) ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cur_r       <= '0;
      lvl_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_acc) begin
        cur_r <= '0;
      end else if (adv && !last_pin) begin
        cur_r <= cur_r + 1'b1;
      end
      if (adv && acc) begin
        lvl_r[cur_r] <= ~lvl_r[cur_r];
        pend_vld_r   <= 1'b1;
      end else if (emit_last) begin
        pend_vld_r   <= 1'b0;
      end
      out_valid_r <= (emit_mid || emit_last) ? 1'b1 : (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      chg_r    <= lvl_r ^ sample_in;
      sample_r <= sample_in;
      now_r    <= in_now_time;
    end
    if (adv && acc) begin
      pend_idx_r <= cur_r;
      pend_prs_r <= ~sample_r[cur_r];
    end
    if (emit_mid || emit_last) begin
      out_idx_r  <= PIN_W'(pend_idx_r);
      out_prs_r  <= pend_prs_r;
      out_last_r <= emit_last;
    end
  end

  assign in_stall       = (st_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pin_index  = out_idx_r;
  assign out_pressed    = out_prs_r;
  assign out_last_event = out_last_r;

endmodule
